/* rtl/knn_majority_classifier_defines.svh */
// Assertion macros for the k-nearest-neighbor classifier.
// Expect a clock named clk and an active-high reset named rst in scope.
`ifndef KNN_MAJORITY_CLASSIFIER_DEFINES_SVH
`define KNN_MAJORITY_CLASSIFIER_DEFINES_SVH

// check cond in the same cycle as trig
`define KNN_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("knn assertion failed");

// check cond in the cycle after trig
`define KNN_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("knn assertion failed");

`endif

/* rtl/knn_pkg.sv */
// Shared types for the k-nearest-neighbor classifier.
// No dependencies; used by knn_cell and knn_majority_classifier.
`timescale 1ns / 1ps

package knn_pkg;

  typedef struct packed {
    logic [31:0] sample_distance;
    logic [7:0]  sample_label;
    logic        last_sample;
  } sample_req_t;

  typedef struct packed {
    logic [7:0] predicted_label;
    logic [4:0] winning_votes;
    logic       short_set;
  } vote_result_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  localparam logic [31:0] REG_NEIGHBOUR_COUNT = 32'd0;

endpackage

/* rtl/knn_cell.sv */
// One slot of the sorted nearest-neighbor chain: insert-by-compare, vote shift.
// Depends on knn_pkg (cell_ctrl_t).
`timescale 1ns / 1ps

module knn_cell #(
  parameter int DIST_BITS = 32,
  parameter int CW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  knn_pkg::cell_ctrl_t  ctrl,
  input  logic [DIST_BITS-1:0] new_dist,
  input  logic [7:0]           new_label,
  input  logic [7:0]           vote_label,
  input  logic                 prev_gt,
  input  logic [DIST_BITS-1:0] prev_dist,
  input  logic [7:0]           prev_label,
  input  logic                 prev_valid,
  input  logic [7:0]           next_label,
  input  logic                 next_valid,
  input  logic [CW-1:0]        next_count,
  output logic [DIST_BITS-1:0] slot_dist,
  output logic [7:0]           label,
  output logic                 valid,
  output logic                 gt,
  output logic [CW-1:0]        count_upd
);

  logic [CW-1:0] count;

  assign gt        = !valid || (slot_dist > new_dist);
  assign count_upd = count + CW'(label == vote_label);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
      count <= '0;
    end else if (ctrl.shift) begin
      label <= next_label;
      valid <= next_valid;
      count <= next_count;
    end else if (ctrl.insert) begin
      count <= '0;
      if (gt && !prev_gt) begin
        slot_dist <= new_dist;
        label     <= new_label;
        valid     <= 1'b1;
      end else if (gt) begin
        slot_dist <= prev_dist;
        label     <= prev_label;
        valid     <= prev_valid;
      end
    end
  end

endmodule

/* rtl/knn_majority_classifier.sv */
// k-nearest-neighbor majority classifier. Each request carries one training
// sample (distance, label); it enters a sorted chain of K_MAX cells as it is
// accepted, so samples are taken back to back with busy low. The request marked
// last is inserted, then busy rises while the chain shifts one entry per cycle
// past the vote counter, nearest first, for min(samples seen, k) votes; ties
// in distance keep the earlier sample ahead, and the first label to reach the
// top count wins. The result is shown with done for one cycle right after the
// vote and cannot be held off, so the receiver must take it then; the chain is
// empty again in that same cycle. short_set flags a set with fewer than k
// samples. k is neighbour_count at address 0 (0 acts as 1, above K_MAX as K_MAX).
// Depends on knn_pkg, knn_cell and knn_majority_classifier_defines.svh.
`timescale 1ns / 1ps
`include "knn_majority_classifier_defines.svh"

module knn_majority_classifier #(
  parameter int K_MAX = 16,
  parameter int DIST_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  knn_pkg::sample_req_t  request,
  output logic                  done,
  output knn_pkg::vote_result_t result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CW = $clog2(K_MAX + 1);
  localparam int KW = (CW > 5) ? CW : 5;

  typedef enum logic {IDLE, VOTE} state_t;

  state_t               state;
  logic [4:0]           neighbour_count;
  logic [CW-1:0]        filled;
  logic [CW-1:0]        remaining;
  logic [CW-1:0]        best;
  logic [7:0]           winner;

  logic [DIST_BITS-1:0] new_dist;
  logic [DIST_BITS-1:0] cell_dist [K_MAX];
  logic [7:0]           cell_label [K_MAX];
  logic                 cell_valid [K_MAX];
  logic                 cell_gt [K_MAX];
  logic [CW-1:0]        cell_count [K_MAX];
  knn_pkg::cell_ctrl_t  ctrl;

  logic                 accept;
  logic                 cfg_write;
  logic [CW-1:0]        filled_ins;
  logic [KW-1:0]        nc_ext;
  logic [KW-1:0]        k_ext;
  logic [CW-1:0]        k_eff;
  logic [CW-1:0]        voters;
  logic [CW-1:0]        best_next;
  logic [7:0]           winner_next;
  logic [CW+4:0]        best_wide;

  generate
    if (DIST_BITS > 32) begin : g_wide
      assign new_dist = {{(DIST_BITS - 32){1'b0}}, request.sample_distance};
    end else if (DIST_BITS == 32) begin : g_even
      assign new_dist = request.sample_distance;
    end else begin : g_narrow
      assign new_dist = request.sample_distance[DIST_BITS-1:0];
    end
  endgenerate

  assign busy      = (state != IDLE);
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (32'(paddr[2]) == knn_pkg::REG_NEIGHBOUR_COUNT) ?
                     32'(neighbour_count) : 32'd0;

  assign ctrl.insert = accept;
  assign ctrl.shift  = (state == VOTE);
  assign ctrl.clear  = (state == VOTE) && (remaining == CW'(1));

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic                 p_gt;
    logic [DIST_BITS-1:0] p_dist;
    logic [7:0]           p_label;
    logic                 p_valid;
    logic [7:0]           n_label;
    logic                 n_valid;
    logic [CW-1:0]        n_count;

    if (i == 0) begin : g_head
      assign p_gt    = 1'b0;
      assign p_dist  = '0;
      assign p_label = '0;
      assign p_valid = 1'b0;
    end else begin : g_body
      assign p_gt    = cell_gt[i-1];
      assign p_dist  = cell_dist[i-1];
      assign p_label = cell_label[i-1];
      assign p_valid = cell_valid[i-1];
    end

    if (i == K_MAX - 1) begin : g_tail
      assign n_label = '0;
      assign n_valid = 1'b0;
      assign n_count = '0;
    end else begin : g_link
      assign n_label = cell_label[i+1];
      assign n_valid = cell_valid[i+1];
      assign n_count = cell_count[i+1];
    end

    knn_cell #(
      .DIST_BITS(DIST_BITS),
      .CW(CW)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctrl(ctrl),
      .new_dist(new_dist),
      .new_label(request.sample_label),
      .vote_label(cell_label[0]),
      .prev_gt(p_gt),
      .prev_dist(p_dist),
      .prev_label(p_label),
      .prev_valid(p_valid),
      .next_label(n_label),
      .next_valid(n_valid),
      .next_count(n_count),
      .slot_dist(cell_dist[i]),
      .label(cell_label[i]),
      .valid(cell_valid[i]),
      .gt(cell_gt[i]),
      .count_upd(cell_count[i])
    );
  end

  always_comb begin
    filled_ins = (filled < CW'(K_MAX)) ? filled + CW'(1) : filled;
    nc_ext     = KW'(neighbour_count);
    if (neighbour_count == 5'd0) begin
      k_ext = KW'(1);
    end else if (nc_ext > KW'(K_MAX)) begin
      k_ext = KW'(K_MAX);
    end else begin
      k_ext = nc_ext;
    end
    k_eff  = k_ext[CW-1:0];
    voters = (filled_ins < k_eff) ? filled_ins : k_eff;

    if (cell_count[0] > best) begin
      best_next   = cell_count[0];
      winner_next = cell_label[0];
    end else begin
      best_next   = best;
      winner_next = winner;
    end
    best_wide = (CW + 5)'(best_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      neighbour_count <= 5'd1;
      filled          <= '0;
      remaining       <= '0;
      done            <= 1'b0;
    end else begin
      done <= (state == VOTE) && (remaining == CW'(1));
      if (cfg_write && (32'(paddr[2]) == knn_pkg::REG_NEIGHBOUR_COUNT)) begin
        neighbour_count <= pwdata[4:0];
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (cell_gt[K_MAX-1]) begin
              filled <= filled_ins;
            end
            if (request.last_sample) begin
              state            <= VOTE;
              remaining        <= voters;
              best             <= '0;
              winner           <= '0;
              result.short_set <= (filled_ins < k_eff);
            end
          end
        end
        VOTE: begin
          best      <= best_next;
          winner    <= winner_next;
          remaining <= remaining - CW'(1);
          if (remaining == CW'(1)) begin
            state                  <= IDLE;
            filled                 <= '0;
            result.predicted_label <= winner_next;
            result.winning_votes   <= (best_wide > (CW + 5)'(31)) ? 5'd31 : best_wide[4:0];
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `KNN_ASSERT_NOW(a_done_idle, done, !busy)
  `KNN_ASSERT_NEXT(a_last_votes, accept && request.last_sample, busy)
  `KNN_ASSERT_NOW(a_fill_bound, 1'b1, filled <= CW'(K_MAX))
  `KNN_ASSERT_NOW(a_votes_nonzero, done, result.winning_votes != 5'd0)

endmodule
